// ===== rtl/tcnw_pkg.sv =====
// shared types, codes and helpers for the text console number writer
package tcnw_pkg;

    // input action codes
    localparam logic [1:0] ACT_CHAR = 2'd0;
    localparam logic [1:0] ACT_DEC  = 2'd1;
    localparam logic [1:0] ACT_HEX  = 2'd2;

    // character codes
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_X       = 8'h78;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;

    // digit store: twenty 4-bit digits, most significant at the top
    localparam int DIGITS  = 20;
    localparam int DIGIT_W = 4 * DIGITS;
    localparam int NUM_W   = 64;

    // fixed field widths
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int ADDR_W = 11;

    // command kinds handed from the front to the back
    typedef enum logic [1:0] {
        CMD_CHAR,
        CMD_NEWLINE,
        CMD_DEC,
        CMD_HEX
    } cmd_kind_t;

    // one queued command
    typedef struct packed {
        cmd_kind_t                kind;
        logic [7:0]               ch;
        logic [DIGIT_W-1:0]       digits;
        logic [4:0]               count;
    } cmd_t;

    // front sequencer states
    typedef enum logic [1:0] {
        FE_IDLE,
        FE_CONV,
        FE_TRIM,
        FE_PUSH
    } fe_state_t;

    // queue status seen by the front and the back
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // ascii code of a digit or uppercase hex nibble
    function automatic logic [7:0] digit_char(input logic [3:0] nib);
        logic [7:0] code;
        if (nib < 4'd10)
            code = CHAR_ZERO + {4'b0, nib};
        else
            code = CHAR_UPPER_A + {4'b0, nib} - 8'd10;
        return code;
    endfunction

endpackage

// ===== rtl/tcnw_front.sv =====
// front part: accepts words, classifies them and converts decimals to bcd
module tcnw_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          in_action,
    input  logic                in_wide,
    input  logic [7:0]          in_character,
    input  logic [63:0]         in_number,
    input  tcnw_pkg::q_status_t q_status,
    output logic                q_push,
    output tcnw_pkg::cmd_t      q_wdata
);

    tcnw_pkg::fe_state_t state_reg, state_next;
    logic [tcnw_pkg::NUM_W-1:0]   bin_reg, bin_next;
    logic [tcnw_pkg::DIGIT_W-1:0] bcd_reg, bcd_next;
    logic [6:0]                   iter_reg, iter_next;
    logic [4:0]                   count_reg, count_next;
    logic [tcnw_pkg::DIGIT_W-1:0] bcd_adj;
    logic [tcnw_pkg::NUM_W-1:0]   num_just;
    logic                         accept;

    // add-3 correction on every bcd digit before the shift
    always_comb
    begin
        for (int i = 0; i < tcnw_pkg::DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    // narrow numbers are moved to the top half
    assign num_just = in_wide ? in_number : {in_number[31:0], 32'b0};
    assign in_ready = (state_reg == tcnw_pkg::FE_IDLE) && !q_status.full;
    assign accept   = in_valid && in_ready;

    // sequencer next state and queue push
    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        iter_next  = iter_reg;
        count_next = count_reg;
        q_push     = 1'b0;
        q_wdata    = '0;
        q_wdata.kind = tcnw_pkg::CMD_CHAR;
        case (state_reg)
            tcnw_pkg::FE_IDLE:
            begin
                if (accept)
                begin
                    case (in_action)
                        tcnw_pkg::ACT_CHAR:
                        begin
                            q_push     = 1'b1;
                            q_wdata.ch = in_character;
                            if (in_character == tcnw_pkg::NEWLINE_CODE)
                                q_wdata.kind = tcnw_pkg::CMD_NEWLINE;
                        end
                        tcnw_pkg::ACT_HEX:
                        begin
                            q_push         = 1'b1;
                            q_wdata.kind   = tcnw_pkg::CMD_HEX;
                            q_wdata.digits = {num_just, 16'b0};
                            q_wdata.count  = in_wide ? 5'd16 : 5'd8;
                        end
                        tcnw_pkg::ACT_DEC:
                        begin
                            bin_next   = num_just;
                            bcd_next   = '0;
                            iter_next  = in_wide ? 7'd64 : 7'd32;
                            state_next = tcnw_pkg::FE_CONV;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            tcnw_pkg::FE_CONV:
            begin
                bcd_next  = {bcd_adj[tcnw_pkg::DIGIT_W-2:0], bin_reg[tcnw_pkg::NUM_W-1]};
                bin_next  = {bin_reg[tcnw_pkg::NUM_W-2:0], 1'b0};
                iter_next = iter_reg - 7'd1;
                if (iter_reg == 7'd1)
                begin
                    count_next = 5'(tcnw_pkg::DIGITS);
                    state_next = tcnw_pkg::FE_TRIM;
                end
            end
            tcnw_pkg::FE_TRIM:
            begin
                // drop leading zero digits, keeping at least one
                if (count_reg > 5'd1 &&
                    bcd_reg[tcnw_pkg::DIGIT_W-1 -: 4] == 4'd0)
                begin
                    bcd_next   = {bcd_reg[tcnw_pkg::DIGIT_W-5:0], 4'b0};
                    count_next = count_reg - 5'd1;
                end
                else
                begin
                    state_next = tcnw_pkg::FE_PUSH;
                end
            end
            tcnw_pkg::FE_PUSH:
            begin
                q_wdata.kind   = tcnw_pkg::CMD_DEC;
                q_wdata.digits = bcd_reg;
                q_wdata.count  = count_reg;
                if (!q_status.full)
                begin
                    q_push     = 1'b1;
                    state_next = tcnw_pkg::FE_IDLE;
                end
            end
            default:
            begin
                state_next = tcnw_pkg::FE_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcnw_pkg::FE_IDLE;
            iter_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            count_reg <= count_next;
        end
    end

    // conversion datapath
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    // checks
    a_conv_iter: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tcnw_pkg::FE_CONV |-> iter_reg != 7'd0)
        else $error("conversion running with no bits left");

    a_trim_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tcnw_pkg::FE_TRIM |-> count_reg != 5'd0)
        else $error("digit count fell to zero");

    a_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && state_reg == tcnw_pkg::FE_PUSH |=> state_reg == tcnw_pkg::FE_IDLE)
        else $error("front did not return to idle after push");

endmodule

// ===== rtl/tcnw_queue.sv =====
// two-entry command queue between the front and the back
module tcnw_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tcnw_pkg::cmd_t      wdata,
    input  logic                pop,
    output tcnw_pkg::cmd_t      rdata,
    output tcnw_pkg::q_status_t status
);

    tcnw_pkg::cmd_t mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_pop;

    assign do_push = push && (fill_reg != 2'd2);
    assign do_pop  = pop && (fill_reg != 2'd0);
    assign status.empty = (fill_reg == 2'd0);
    assign status.full  = (fill_reg == 2'd2);
    assign rdata = mem[rd_ptr_reg];

    // fill level
    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 2'd1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 2'd1;
    end

    // pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            fill_reg <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wdata;
    end

    // checks
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("queue fill out of range");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'd0 || fill_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with fill");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && status.full && !pop |=> fill_reg == 2'd2)
        else $error("queue fill changed on a refused push");

endmodule

// ===== rtl/tcnw_back.sv =====
// back part: runs commands, keeps the cursor and drives the write stream
module tcnw_back
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [7:0]                    cfg_wdata,
    input  tcnw_pkg::cmd_t                q_rdata,
    input  tcnw_pkg::q_status_t           q_status,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tcnw_pkg::ADDR_W-1:0]   out_address,
    output logic [15:0]                   out_data,
    output logic                          out_last
);

    logic [7:0]                    attr_reg;
    logic [tcnw_pkg::ROW_W-1:0]    row_reg, row_next, row_inc;
    logic [tcnw_pkg::COL_W-1:0]    col_reg, col_next;
    logic                          busy_reg, busy_next;
    logic [1:0]                    prefix_reg, prefix_next;
    logic [tcnw_pkg::DIGIT_W-1:0]  digits_reg, digits_next;
    logic [4:0]                    left_reg, left_next;
    logic                          oval_reg, oval_next;
    logic [tcnw_pkg::ADDR_W-1:0]   oaddr_reg, oaddr_next;
    logic [15:0]                   odata_reg, odata_next;
    logic                          olast_reg, olast_next;
    logic                          slot_free, emit, emit_last, col_wrap;
    logic [7:0]                    emit_ch;
    logic [12:0]                   addr_full;

    assign slot_free = !oval_reg || out_ready;
    assign col_wrap  = ({1'b0, col_reg} + 8'd1) == 8'(COLUMNS);
    assign row_inc   = (({1'b0, row_reg} + 6'd1) == 6'(ROWS)) ? '0 : row_reg + 5'd1;
    assign addr_full = 13'(row_reg) * 13'(COLUMNS) + 13'(col_reg);

    // command sequencing and cursor update
    always_comb
    begin
        row_next    = row_reg;
        col_next    = col_reg;
        busy_next   = busy_reg;
        prefix_next = prefix_reg;
        digits_next = digits_reg;
        left_next   = left_reg;
        q_pop       = 1'b0;
        emit        = 1'b0;
        emit_ch     = '0;
        emit_last   = 1'b0;
        if (slot_free)
        begin
            if (busy_reg)
            begin
                emit = 1'b1;
                if (prefix_reg != 2'd0)
                begin
                    emit_ch     = (prefix_reg == 2'd2) ? tcnw_pkg::CHAR_ZERO : tcnw_pkg::CHAR_X;
                    prefix_next = prefix_reg - 2'd1;
                end
                else
                begin
                    emit_ch     = tcnw_pkg::digit_char(digits_reg[tcnw_pkg::DIGIT_W-1 -: 4]);
                    digits_next = {digits_reg[tcnw_pkg::DIGIT_W-5:0], 4'b0};
                    left_next   = left_reg - 5'd1;
                    emit_last   = (left_reg == 5'd1);
                    if (left_reg == 5'd1)
                        busy_next = 1'b0;
                end
            end
            else if (!q_status.empty)
            begin
                q_pop = 1'b1;
                case (q_rdata.kind)
                    tcnw_pkg::CMD_CHAR:
                    begin
                        emit      = 1'b1;
                        emit_ch   = q_rdata.ch;
                        emit_last = 1'b1;
                    end
                    tcnw_pkg::CMD_NEWLINE:
                    begin
                        col_next = '0;
                        row_next = row_inc;
                    end
                    tcnw_pkg::CMD_DEC:
                    begin
                        busy_next   = 1'b1;
                        prefix_next = 2'd0;
                        digits_next = q_rdata.digits;
                        left_next   = q_rdata.count;
                    end
                    tcnw_pkg::CMD_HEX:
                    begin
                        busy_next   = 1'b1;
                        prefix_next = 2'd2;
                        digits_next = q_rdata.digits;
                        left_next   = q_rdata.count;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        // cursor moves after every written cell
        if (emit)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_inc;
            end
            else
            begin
                col_next = col_reg + 7'd1;
            end
        end
    end

    // output register
    always_comb
    begin
        oval_next  = oval_reg;
        oaddr_next = oaddr_reg;
        odata_next = odata_reg;
        olast_next = olast_reg;
        if (slot_free)
        begin
            oval_next  = emit;
            oaddr_next = addr_full[tcnw_pkg::ADDR_W-1:0];
            odata_next = {attr_reg, emit_ch};
            olast_next = emit_last;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg   <= 8'd10;
            row_reg    <= '0;
            col_reg    <= '0;
            busy_reg   <= 1'b0;
            prefix_reg <= '0;
            left_reg   <= '0;
            oval_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
                attr_reg <= cfg_wdata;
            row_reg    <= row_next;
            col_reg    <= col_next;
            busy_reg   <= busy_next;
            prefix_reg <= prefix_next;
            left_reg   <= left_next;
            oval_reg   <= oval_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        oaddr_reg  <= oaddr_next;
        odata_reg  <= odata_next;
        olast_reg  <= olast_next;
    end

    assign out_valid   = oval_reg;
    assign out_address = oaddr_reg;
    assign out_data    = odata_reg;
    assign out_last    = olast_reg;

    // checks
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, col_reg} < 8'(COLUMNS))
        else $error("cursor column past line end");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, row_reg} < 6'(ROWS))
        else $error("cursor row past last row");

    a_busy_left: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> left_reg != 5'd0)
        else $error("busy with no digits left");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !busy_reg)
        else $error("command popped while another runs");

endmodule

// ===== rtl/text_console_number_writer_core.sv =====
// top level of the text console number writer
// Input words carry one console action: print a character (newline moves
// the cursor to column 0 of the next row), print a number in unsigned
// decimal without leading zeros, or print 0x and 8 or 16 uppercase hex digits.
// Each printed character leaves as one output word: the framebuffer cell
// index row*COLUMNS+col and the attribute byte over the character byte,
// with tlast on the final cell of the action. The cursor wraps at line end
// and past the last row back to row 0.
// The front takes a word when idle and the two-entry queue has room:
// character and hex words enter the queue at once; a decimal word runs a
// shift-and-add-3 conversion over 32 or 64 bits, then drops up to 19
// leading zero digits, and only then is queued.
// The back drains the queue: a character command writes its cell when
// popped; a number command is loaded first and then prints its characters
// one after another (10 or 18 for hex, 1 to 20 for decimal). A character
// word passes through the queue and the output register before it leaves.
// A stall on the output holds the output register and the back; the queue
// and the front keep working until the queue is full.
// Reset puts the cursor at row 0, column 0, attribute 10, queue empty.
module text_console_number_writer_core
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // character [7:0], number [71:8]
    input  logic [2:0]  s_tuser,   // action [1:0], wide [2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cell_address [10:0], cell_data [26:11], zero [31:27]
    output logic        m_tlast
);

    tcnw_pkg::cmd_t      q_wdata, q_rdata;
    tcnw_pkg::q_status_t q_status;
    logic                q_push, q_pop;
    logic [tcnw_pkg::ADDR_W-1:0] out_address;
    logic [15:0]         out_data;

    // accept and classify
    tcnw_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_action    (s_tuser[1:0]),
        .in_wide      (s_tuser[2]),
        .in_character (s_tdata[7:0]),
        .in_number    (s_tdata[71:8]),
        .q_status     (q_status),
        .q_push       (q_push),
        .q_wdata      (q_wdata)
    );

    // command queue
    tcnw_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    // cell writer
    tcnw_back
    #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .q_rdata     (q_rdata),
        .q_status    (q_status),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_address (out_address),
        .out_data    (out_data),
        .out_last    (m_tlast)
    );

    // output packing
    assign m_tdata = {5'b0, out_data, out_address};

endmodule

// ===== sim/tb_text_console_number_writer_core.sv =====
`timescale 1ns / 1ps
// testbench for the text console number writer core: directed and random console actions
module tb_text_console_number_writer_core;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;

    // action code the block ignores
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // cycles to let a decimal conversion or a trailing newline finish
    localparam int SETTLE_CYCLES = 150;
    localparam int CYCLE_LIMIT   = 500000;

    // one framebuffer write as seen on the output
    typedef struct packed {
        logic [10:0] addr;
        logic [15:0] data;
        logic        last;
    } cell_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wen;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // character [7:0], number [71:8]
    logic [2:0]  s_tuser;   // action [1:0], wide [2]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // cell_address [10:0], cell_data [26:11], zero [31:27]
    logic        m_tlast;

    // console state mirrored by the testbench
    cell_t       expected_cells[$];
    logic [7:0]  text_attr;
    int unsigned cursor_row;
    int unsigned cursor_col;

    int          failures    = 0;
    int unsigned cycle_count = 0;
    bit          idle_on     = 1'b1;

    text_console_number_writer_core
    #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    )
    DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // cursor moves down one row, back to the top past the last row
    function automatic void advance_row();
        cursor_row = cursor_row + 1;
        if (cursor_row >= ROWS)
            cursor_row = 0;
    endfunction

    // expected write of one character at the cursor, then cursor step
    task automatic place_cell(input logic [7:0] ch);
        cell_t c;
        c.addr = 11'(cursor_row * COLUMNS + cursor_col);
        c.data = {text_attr, ch};
        c.last = 1'b0;
        expected_cells.push_back(c);
        cursor_col = cursor_col + 1;
        if (cursor_col >= COLUMNS)
        begin
            cursor_col = 0;
            advance_row();
        end
    endtask

    // all cell writes one console action produces
    task automatic print_to_console(input logic [1:0] action, input logic [7:0] ch,
                                    input logic [63:0] num, input logic wide);
        logic [63:0] value;
        logic [7:0]  digits [20];
        int          n;
        int          i;
        int          len;
        int          prior_count;
        string       hex_set;
        cell_t       tail;
        value       = wide ? num : {32'b0, num[31:0]};
        n           = 0;
        hex_set     = "0123456789ABCDEF";
        prior_count = expected_cells.size();
        case (action)
            tcnw_pkg::ACT_CHAR:
            begin
                if (ch == tcnw_pkg::NEWLINE_CODE)
                begin
                    cursor_col = 0;
                    advance_row();
                end
                else
                    place_cell(ch);
            end
            tcnw_pkg::ACT_DEC:
            begin
                if (value == 64'd0)
                    place_cell(tcnw_pkg::CHAR_ZERO);
                // digits come out least significant first
                while (value != 64'd0)
                begin
                    digits[n] = tcnw_pkg::CHAR_ZERO + 8'(value % 64'd10);
                    value     = value / 64'd10;
                    n++;
                end
                for (i = n - 1; i >= 0; i--)
                    place_cell(digits[i]);
            end
            tcnw_pkg::ACT_HEX:
            begin
                len = wide ? 16 : 8;
                place_cell(tcnw_pkg::CHAR_ZERO);
                place_cell(tcnw_pkg::CHAR_X);
                for (i = len - 1; i >= 0; i--)
                    place_cell(hex_set[value[4*i +: 4]]);
            end
            default:
            begin
            end
        endcase
        // flag the final write of the action
        if (expected_cells.size() > prior_count)
        begin
            tail      = expected_cells.pop_back();
            tail.last = 1'b1;
            expected_cells.push_back(tail);
        end
    endtask

    // send one input word and record what it should print
    task automatic send_console_word(input logic [1:0] action, input logic [7:0] ch,
                                     input logic [63:0] num, input logic wide);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {num, ch};
        s_tuser  = {wide, action};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        print_to_console(action, ch, num, wide);
    endtask

    // wait until every expected word is out and the block has gone quiet
    task automatic wait_quiet();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // attribute register write while idle
    task automatic set_attribute(input logic [7:0] value);
        wait_quiet();
        @(negedge clk);
        cfg_wen   = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_wen   = 1'b0;
        text_attr = value;
    endtask

    // plain characters at the byte extremes
    task automatic test_characters();
        send_console_word(tcnw_pkg::ACT_CHAR, 8'h41, 64'd0, 1'b0);
        send_console_word(tcnw_pkg::ACT_CHAR, 8'h00, 64'd0, 1'b0);
        send_console_word(tcnw_pkg::ACT_CHAR, 8'hFF, {64{1'b1}}, 1'b1);
        send_console_word(tcnw_pkg::ACT_CHAR, 8'h7E, 64'd0, 1'b0);
    endtask

    // newline mid line, newline at column zero, then a character
    task automatic test_newline();
        send_console_word(tcnw_pkg::ACT_CHAR, tcnw_pkg::NEWLINE_CODE, 64'd0, 1'b0);
        send_console_word(tcnw_pkg::ACT_CHAR, tcnw_pkg::NEWLINE_CODE, {64{1'b1}}, 1'b1);
        send_console_word(tcnw_pkg::ACT_CHAR, 8'h42, 64'd0, 1'b0);
    endtask

    // decimal zero, narrow and wide maxima, ignored high half
    task automatic test_decimal();
        send_console_word(tcnw_pkg::ACT_DEC, 8'h00, 64'd0, 1'b0);
        send_console_word(tcnw_pkg::ACT_DEC, 8'hFF, 64'd0, 1'b1);
        send_console_word(tcnw_pkg::ACT_DEC, 8'h00, {64{1'b1}}, 1'b0);
        send_console_word(tcnw_pkg::ACT_DEC, 8'h00, {64{1'b1}}, 1'b1);
        send_console_word(tcnw_pkg::ACT_DEC, 8'h00, {32'hDEADBEEF, 32'd0}, 1'b0);
        send_console_word(tcnw_pkg::ACT_DEC, 8'h00, 64'd10000000000000000000, 1'b1);
    endtask

    // hex in both widths with every digit value
    task automatic test_hex();
        send_console_word(tcnw_pkg::ACT_HEX, 8'h00, 64'h0123_4567_89AB_CDEF, 1'b0);
        send_console_word(tcnw_pkg::ACT_HEX, 8'h00, 64'h0123_4567_89AB_CDEF, 1'b1);
        send_console_word(tcnw_pkg::ACT_HEX, 8'h00, 64'd0, 1'b1);
        send_console_word(tcnw_pkg::ACT_HEX, 8'h00, {64{1'b1}}, 1'b0);
    endtask

    // ignored action leaves the cursor where it was
    task automatic test_unknown_action();
        send_console_word(ACT_UNUSED, 8'hFF, {64{1'b1}}, 1'b1);
        send_console_word(ACT_UNUSED, 8'h41, 64'd12345, 1'b0);
        send_console_word(tcnw_pkg::ACT_CHAR, 8'h43, 64'd0, 1'b0);
    endtask

    // attribute byte at its extremes and a random value
    task automatic test_attribute_settings();
        set_attribute(8'h00);
        send_console_word(tcnw_pkg::ACT_CHAR, 8'h44, 64'd0, 1'b0);
        set_attribute(8'hFF);
        send_console_word(tcnw_pkg::ACT_HEX, 8'h00, 64'hFEDC_BA98_7654_3210, 1'b1);
        set_attribute(8'($urandom_range(0, 255)));
        send_console_word(tcnw_pkg::ACT_DEC, 8'h00, 64'd987654321, 1'b0);
    endtask

    // random mix of actions with varied number magnitudes
    task automatic test_random_mix(input int count);
        int          pick;
        logic [1:0]  action;
        logic [7:0]  ch;
        logic [63:0] num;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            ch   = 8'($urandom_range(0, 255));
            num  = {$urandom, $urandom};
            if ($urandom_range(0, 3) == 0)
                num = num >> $urandom_range(0, 63);
            if (pick < 10)
            begin
                action = tcnw_pkg::ACT_CHAR;
                ch     = tcnw_pkg::NEWLINE_CODE;
            end
            else if (pick < 35)
                action = tcnw_pkg::ACT_CHAR;
            else if (pick < 62)
                action = tcnw_pkg::ACT_DEC;
            else if (pick < 92)
                action = tcnw_pkg::ACT_HEX;
            else
                action = ACT_UNUSED;
            send_console_word(action, ch, num, 1'($urandom_range(0, 1)));
        end
    endtask

    // output side readiness with random stalls
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 3) : 0;
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready))
                @(posedge clk);
        end
    end

    // compare each output word with the oldest expected cell
    always @(posedge clk)
    begin : check_cells
        cell_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_cells.size() == 0)
            begin
                $error("output word with no cell expected: tdata %h tlast %b", m_tdata, m_tlast);
                failures++;
            end
            else
            begin
                want = expected_cells.pop_front();
                if (m_tdata[10:0] != want.addr)
                begin
                    $error("cell_address mismatch: expected %0d, actual %0d",
                           want.addr, m_tdata[10:0]);
                    failures++;
                end
                if (m_tdata[26:11] != want.data)
                begin
                    $error("cell_data mismatch: expected %h, actual %h",
                           want.data, m_tdata[26:11]);
                    failures++;
                end
                if (m_tlast != want.last)
                begin
                    $error("last mismatch: expected %b, actual %b", want.last, m_tlast);
                    failures++;
                end
            end
        end
    end

    // reset, directed tests, random phases, final verdict
    initial
    begin
        rst_n      = 1'b0;
        cfg_wen    = 1'b0;
        cfg_wdata  = 8'h00;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        text_attr  = 8'd10;
        cursor_row = 0;
        cursor_col = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_characters();
        test_newline();
        test_decimal();
        test_hex();
        test_unknown_action();
        test_attribute_settings();

        set_attribute(8'hFF);
        idle_on = 1'b1;
        test_random_mix(70);
        set_attribute(8'h00);
        idle_on = 1'b0;
        test_random_mix(60);
        set_attribute(8'($urandom_range(0, 255)));
        idle_on = 1'b1;
        test_random_mix(70);
        set_attribute(8'd10);
        test_random_mix(60);

        wait_quiet();
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tcnw_pkg.sv
rtl/tcnw_front.sv
rtl/tcnw_queue.sv
rtl/tcnw_back.sv
rtl/text_console_number_writer_core.sv
sim/tb_text_console_number_writer_core.sv
